### rtl/kfip_pkg.sv
// Package for the keyed Feistel index permuter: widths, key-schedule
// constants and the round/permute functions.
// No dependencies.
`default_nettype none

package kfip_pkg;

    localparam int unsigned IndexW   = 32;
    localparam int unsigned HalfW    = 6;
    localparam int unsigned DomainW  = 2 * HalfW;
    localparam int unsigned Rounds   = 4;
    localparam int unsigned KeyW     = 32;
    localparam int unsigned SessionW = 64;
    localparam int unsigned FrameW   = 32;
    localparam int unsigned CfgDataW = 64;
    localparam int unsigned CfgIdxW  = 2;

    // Register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] RegSession = 2'd0;
    localparam logic [CfgIdxW-1:0] RegFrame   = 2'd1;

    // Direction codes
    localparam logic KindForward = 1'b0;
    localparam logic KindInverse = 1'b1;

    // Murmur3 finalizer multipliers
    localparam logic [KeyW-1:0] MixMulA = 32'h85EB_CA6B;
    localparam logic [KeyW-1:0] MixMulB = 32'hC2B2_AE35;

    typedef logic [Rounds-1:0][KeyW-1:0] key_arr_t;

    // Per-round offsets: i times the golden ratio constant, mod 2^32
    localparam key_arr_t RoundStep = '{32'hDAA6_6D2B, 32'h3C6E_F372,
                                       32'h9E37_79B9, 32'h0000_0000};

    typedef logic [HalfW-1:0] half_t;

    function automatic half_t round_fn(input half_t h, input logic [KeyW-1:0] key);
        logic [KeyW-1:0] v;
        v = {2'b00, h, h, h, h, h};
        v = v ^ key;
        v = v + (key >> 3);
        v = v ^ {v[26:0], v[31:27]};
        v = v + (key >> 7);
        v = v ^ {v[20:0], v[31:21]};
        return v[HalfW-1:0];
    endfunction

    function automatic logic [DomainW-1:0] permute(input logic [DomainW-1:0] idx,
                                                    input logic inv,
                                                    input key_arr_t keys);
        half_t hi;
        half_t lo;
        half_t t;
        hi = idx[DomainW-1:HalfW];
        lo = idx[HalfW-1:0];
        if (inv == KindForward)
        begin
            for (int r = 0; r < Rounds; r++)
            begin
                t  = lo;
                lo = hi ^ round_fn(lo, keys[r]);
                hi = t;
            end
        end
        else
        begin
            for (int r = Rounds - 1; r >= 0; r--)
            begin
                t  = hi;
                hi = lo ^ round_fn(hi, keys[r]);
                lo = t;
            end
        end
        return {hi, lo};
    endfunction

endpackage

`default_nettype wire

### rtl/keyed_feistel_index_permuter.sv
// Top level of the keyed Feistel index permuter: key schedule pipeline,
// input register, four-round Feistel datapath and result register.
// Depends on kfip_pkg.
`default_nettype none

//  channel | signals                              | dir | beat accepted when
//  --------+--------------------------------------+-----+--------------------------
//  in      | in_valid, in_stall, kind, index      | in  | in_valid && !in_stall
//  out     | out_valid, out_stall, mapped_index   | out | out_valid && !out_stall
//  cfg     | cfg_write, cfg_index, cfg_data       | in  | cfg_write
//
// One beat per cycle unless a key refill or out_stall holds the flow; a beat
// accepted goes to the input register, then through four unrolled rounds into
// the result register once that is free or draining. After reset and every
// configuration write, the four-stage key pipeline (base, two finalizer
// multiplies, final xor) refills while in_stall stays high. A stalled result
// does not block the input register: one more beat is taken and held behind it.

module keyed_feistel_index_permuter
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           in_valid,
    output      logic                           in_stall,
    input  wire logic                           kind,
    input  wire logic [kfip_pkg::IndexW-1:0]    index,

    output      logic                           out_valid,
    input  wire logic                           out_stall,
    output      logic [kfip_pkg::IndexW-1:0]    mapped_index,

    input  wire logic                           cfg_write,
    input  wire logic [kfip_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [kfip_pkg::CfgDataW-1:0]  cfg_data
);

    localparam logic [2:0] KeyFill = 3'd4;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [kfip_pkg::SessionW-1:0] session_reg;
    logic [kfip_pkg::FrameW-1:0]   frame_reg;
    logic [2:0]                    key_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_reg  <= '0;
            frame_reg    <= '0;
            key_busy_reg <= KeyFill;
        end
        else
        begin
            if (cfg_write && cfg_index == kfip_pkg::RegSession)
            begin
                session_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == kfip_pkg::RegFrame)
            begin
                frame_reg <= cfg_data[kfip_pkg::FrameW-1:0];
            end
            // Any write restarts the key refill; unknown indexes change no
            // register, so the refilled keys come out the same.
            if (cfg_write)
            begin
                key_busy_reg <= KeyFill;
            end
            else if (key_busy_reg != 3'd0)
            begin
                key_busy_reg <= key_busy_reg - 3'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Key schedule: free-running pipeline, one lane per round key
    // ------------------------------------------------------------------
    logic [kfip_pkg::KeyW-1:0] base_reg;
    kfip_pkg::key_arr_t        mul_a_reg;
    kfip_pkg::key_arr_t        mul_b_reg;
    kfip_pkg::key_arr_t        key_reg;
    kfip_pkg::key_arr_t        mix_a_in;
    kfip_pkg::key_arr_t        mix_b_in;
    kfip_pkg::key_arr_t        key_next;

    always_comb
    begin
        for (int i = 0; i < kfip_pkg::Rounds; i++)
        begin
            mix_a_in[i] = (base_reg ^ kfip_pkg::RoundStep[i])
                        ^ ((base_reg ^ kfip_pkg::RoundStep[i]) >> 16);
            mix_b_in[i] = mul_a_reg[i] ^ (mul_a_reg[i] >> 13);
            key_next[i] = mul_b_reg[i] ^ (mul_b_reg[i] >> 16);
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= (session_reg[kfip_pkg::KeyW-1:0] + frame_reg)
                  ^ session_reg[kfip_pkg::SessionW-1:kfip_pkg::KeyW];
        for (int i = 0; i < kfip_pkg::Rounds; i++)
        begin
            mul_a_reg[i] <= mix_a_in[i] * kfip_pkg::MixMulA;
            mul_b_reg[i] <= mix_b_in[i] * kfip_pkg::MixMulB;
        end
        key_reg <= key_next;
    end

    // ------------------------------------------------------------------
    // Input register and result register (elastic two-stage pipe)
    // ------------------------------------------------------------------
    logic                         s1_vld_reg;
    logic                         s1_kind_reg;
    logic [kfip_pkg::IndexW-1:0]  s1_index_reg;
    logic                         out_vld_reg;
    logic [kfip_pkg::IndexW-1:0]  out_data_reg;
    logic                         s1_move;
    logic                         in_take;
    logic [kfip_pkg::IndexW-1:0]  result_next;

    // Advance the held beat when the result register is free or being drained
    assign s1_move  = s1_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = (key_busy_reg != 3'd0) || (s1_vld_reg && !s1_move);
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        // Out-of-domain indexes pass through untouched
        if (s1_index_reg[kfip_pkg::IndexW-1:kfip_pkg::DomainW] != '0)
        begin
            result_next = s1_index_reg;
        end
        else
        begin
            result_next = {{(kfip_pkg::IndexW - kfip_pkg::DomainW){1'b0}},
                           kfip_pkg::permute(s1_index_reg[kfip_pkg::DomainW-1:0],
                                             s1_kind_reg, key_reg)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_vld_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_vld_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_kind_reg  <= kind;
            s1_index_reg <= index;
        end
        if (s1_move)
        begin
            out_data_reg <= result_next;
        end
    end

    assign out_valid    = out_vld_reg;
    assign mapped_index = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A configuration write must hold off input until the keys are refilled
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> in_stall)
        else $error("input not stalled after configuration write");

    // Out-of-domain beats reach the result register unchanged
    a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_index_reg[kfip_pkg::IndexW-1:kfip_pkg::DomainW] != '0)
        |=> (mapped_index == $past(s1_index_reg)))
        else $error("out-of-domain index was altered");

    // A beat held behind a stalled result keeps its payload
    a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && out_vld_reg && out_stall)
        |=> (s1_vld_reg && $stable(s1_index_reg) && $stable(s1_kind_reg)))
        else $error("held beat lost or changed");

endmodule

`default_nettype wire

### dv/tb_top.sv
// Testbench for keyed_feistel_index_permuter: streams index beats through several
// key settings under random idling and checks each mapped index against a local predictor.
// Depends on kfip_pkg and the permuter RTL.

module tb_top;

    // No-progress limit: the longest correct quiet stretch is a run of receiver
    // stalls at 80 percent or a key refill, both far below this.
    localparam int unsigned StallLimit    = 2000;
    localparam int unsigned BeatsPerPhase = 200;
    localparam int unsigned NumPhases     = 8;
    localparam int unsigned NumDirected   = 20;

    // Key schedule constants of the predictor
    localparam logic [kfip_pkg::KeyW-1:0]   GoldenStep = 32'h9E37_79B9;
    localparam logic [kfip_pkg::KeyW-1:0]   FinalMulA  = 32'h85EB_CA6B;
    localparam logic [kfip_pkg::KeyW-1:0]   FinalMulB  = 32'hC2B2_AE35;
    localparam logic [kfip_pkg::IndexW-1:0] DomainTop  = 32'h0000_0FFF;

    // Register indexes that decode to nothing
    localparam logic [kfip_pkg::CfgIdxW-1:0] RegSpareA = 2'd2;
    localparam logic [kfip_pkg::CfgIdxW-1:0] RegSpareB = 2'd3;

    typedef struct packed {
        logic                        dir;
        logic [kfip_pkg::IndexW-1:0] idx;
        logic                        pinned;  // want is typed in, not predicted
        logic [kfip_pkg::IndexW-1:0] want;
    } stim_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic                          kind;
    logic [kfip_pkg::IndexW-1:0]   index;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [kfip_pkg::IndexW-1:0]   mapped_index;
    logic                          cfg_write;
    logic [kfip_pkg::CfgIdxW-1:0]  cfg_index;
    logic [kfip_pkg::CfgDataW-1:0] cfg_data;

    // Predictor copy of the registers and the derived round keys
    logic [kfip_pkg::SessionW-1:0] sess_val;
    logic [kfip_pkg::FrameW-1:0]   frame_val;
    logic [kfip_pkg::KeyW-1:0]     round_key [kfip_pkg::Rounds];

    // Mapped indexes still owed by the block, oldest first
    logic [kfip_pkg::IndexW-1:0]   pending_maps [$];

    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned send_idle_pct  = 31;
    int unsigned recv_stall_pct = 80;

    // Directed beats: range extremes, half patterns, both directions, and
    // out-of-domain indexes whose result is the index itself.
    stim_row_t directed_rows [0:NumDirected-1] = '{
        '{kfip_pkg::KindForward, 32'h0000_0000, 1'b0, 32'h0},
        '{kfip_pkg::KindInverse, 32'h0000_0000, 1'b0, 32'h0},
        '{kfip_pkg::KindForward, 32'h0000_0FFF, 1'b0, 32'h0},
        '{kfip_pkg::KindInverse, 32'h0000_0FFF, 1'b0, 32'h0},
        '{kfip_pkg::KindForward, 32'h0000_003F, 1'b0, 32'h0},
        '{kfip_pkg::KindInverse, 32'h0000_0FC0, 1'b0, 32'h0},
        '{kfip_pkg::KindForward, 32'h0000_0FC0, 1'b0, 32'h0},
        '{kfip_pkg::KindInverse, 32'h0000_003F, 1'b0, 32'h0},
        '{kfip_pkg::KindForward, 32'h0000_0555, 1'b0, 32'h0},
        '{kfip_pkg::KindInverse, 32'h0000_0AAA, 1'b0, 32'h0},
        '{kfip_pkg::KindForward, 32'h0000_0800, 1'b0, 32'h0},
        '{kfip_pkg::KindInverse, 32'h0000_0001, 1'b0, 32'h0},
        // first index past the domain, then the far end of the field
        '{kfip_pkg::KindForward, 32'h0000_1000, 1'b1, 32'h0000_1000},
        '{kfip_pkg::KindInverse, 32'h0000_1000, 1'b1, 32'h0000_1000},
        '{kfip_pkg::KindForward, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{kfip_pkg::KindInverse, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{kfip_pkg::KindForward, 32'h8000_0000, 1'b1, 32'h8000_0000},
        '{kfip_pkg::KindInverse, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
        // low twelve bits all zero or all one, upper bits set
        '{kfip_pkg::KindForward, 32'hFFFF_F000, 1'b1, 32'hFFFF_F000},
        '{kfip_pkg::KindInverse, 32'h0000_1FFF, 1'b1, 32'h0000_1FFF}
    };

    keyed_feistel_index_permuter u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .index        (index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mapped_index (mapped_index),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // Murmur3 finalizer used by the key schedule
    function automatic logic [kfip_pkg::KeyW-1:0] murmur_tail(
        input logic [kfip_pkg::KeyW-1:0] s);
        logic [kfip_pkg::KeyW-1:0] m;
        m = s ^ (s >> 16);
        m = m * FinalMulA;
        m = m ^ (m >> 13);
        m = m * FinalMulB;
        m = m ^ (m >> 16);
        return m;
    endfunction

    // Recompute all four keys from the current register pair; only the low
    // word of the 64-bit sum is kept, so a carry out of it is dropped.
    function automatic void rebuild_round_keys();
        logic [kfip_pkg::SessionW-1:0] sum;
        logic [kfip_pkg::KeyW-1:0]     base;
        logic [kfip_pkg::KeyW-1:0]     offset;
        sum    = sess_val + {32'd0, frame_val};
        base   = sum[31:0] ^ sess_val[63:32];
        offset = '0;
        for (int i = 0; i < kfip_pkg::Rounds; i++)
        begin
            round_key[i] = murmur_tail(base ^ offset);
            offset       = offset + GoldenStep;
        end
    endfunction

    // Round function: five copies of the half in bits 29:0, bits 31:30 clear
    function automatic logic [kfip_pkg::HalfW-1:0] half_mix(
        input logic [kfip_pkg::HalfW-1:0] h,
        input logic [kfip_pkg::KeyW-1:0]  key);
        logic [kfip_pkg::KeyW-1:0] v;
        v = '0;
        for (int c = 0; c < 5; c++)
            v = v | ({26'd0, h} << (6 * c));
        v = v ^ key;
        v = v + (key >> 3);
        v = v ^ ((v << 5) | (v >> 27));
        v = v + (key >> 7);
        v = v ^ ((v << 11) | (v >> 21));
        return v[kfip_pkg::HalfW-1:0];
    endfunction

    // Expected mapped index for one beat under the current keys
    function automatic logic [kfip_pkg::IndexW-1:0] feistel_map(
        input logic                        dir,
        input logic [kfip_pkg::IndexW-1:0] idx);
        logic [kfip_pkg::HalfW-1:0] hi;
        logic [kfip_pkg::HalfW-1:0] lo;
        logic [kfip_pkg::HalfW-1:0] t;
        if (idx > DomainTop)
            return idx;
        hi = idx[11:6];
        lo = idx[5:0];
        if (dir == kfip_pkg::KindForward)
        begin
            for (int r = 0; r < kfip_pkg::Rounds; r++)
            begin
                t  = lo;
                lo = hi ^ half_mix(lo, round_key[r]);
                hi = t;
            end
        end
        else
        begin
            for (int r = kfip_pkg::Rounds - 1; r >= 0; r--)
            begin
                t  = hi;
                hi = lo ^ half_mix(hi, round_key[r]);
                lo = t;
            end
        end
        return {20'd0, hi, lo};
    endfunction

    task automatic flag_mismatch(input string what,
                                 input logic [kfip_pkg::IndexW-1:0] got,
                                 input logic [kfip_pkg::IndexW-1:0] want);
        $display("MISMATCH %s: mapped_index %08h, expected %08h at %0t",
                 what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Offer one beat, hold it until taken, then log what it must map to.
    // Call and return on a rising edge; valid stays high after the beat.
    task automatic send_beat(input logic dir, input logic [kfip_pkg::IndexW-1:0] idx,
                             input logic [kfip_pkg::IndexW-1:0] want);
        logic taken;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= dir;
        index    <= idx;
        taken    = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        pending_maps.push_back(want);
    endtask

    // Pulse one register write, then update the predictor's copy
    task automatic write_reg(input logic [kfip_pkg::CfgIdxW-1:0]  sel,
                             input logic [kfip_pkg::CfgDataW-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (sel == kfip_pkg::RegSession)
        begin
            sess_val = data;
            rebuild_round_keys();
        end
        else if (sel == kfip_pkg::RegFrame)
        begin
            frame_val = data[kfip_pkg::FrameW-1:0];
            rebuild_round_keys();
        end
    endtask

    // Wait out every owed result, then let the two-stage datapath settle
    task automatic drain_results();
        while (pending_maps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_beat();
        int unsigned                 pick;
        logic                        dir;
        logic [kfip_pkg::IndexW-1:0] idx;
        pick = $urandom_range(99, 0);
        dir  = 1'($urandom_range(1, 0));
        if (pick < 60)
            idx = $urandom_range(4095, 0);
        else if (pick < 75)
            // round trip: feed back the opposite mapping of a random index
            idx = feistel_map(!dir, $urandom_range(4095, 0));
        else if (pick < 85)
            idx = 32'd4096 + $urandom_range(63, 0);
        else
            idx = $urandom();
        send_beat(dir, idx, feistel_map(dir, idx));
    endtask

    // Key setting for each phase; the reset keys stand in phase zero
    task automatic apply_setting(input int unsigned phase);
        case (phase)
            1:
            begin
                write_reg(kfip_pkg::RegSession, '1);
                write_reg(kfip_pkg::RegFrame, 64'h0000_0000_FFFF_FFFF);
            end
            2:
            begin
                // spare index must leave the keys alone; low word sum wraps
                write_reg(RegSpareA, {$urandom(), $urandom()});
                write_reg(kfip_pkg::RegSession, 64'h0000_0001_FFFF_FFFF);
                write_reg(kfip_pkg::RegFrame, 64'd1);
            end
            3:
            begin
                // upper half of the frame write is dropped
                write_reg(kfip_pkg::RegSession, {$urandom(), $urandom()});
                write_reg(kfip_pkg::RegFrame, {32'hFFFF_FFFF, $urandom()});
            end
            4:
            begin
                write_reg(RegSpareB, '1);
                write_reg(kfip_pkg::RegSession, 64'h8000_0000_0000_0000);
            end
            5:
            begin
                write_reg(kfip_pkg::RegFrame, '0);
                write_reg(kfip_pkg::RegSession, {$urandom(), $urandom()});
            end
            6:
            begin
                write_reg(kfip_pkg::RegSession, '0);
                write_reg(kfip_pkg::RegFrame, '0);
            end
            7:
            begin
                write_reg(kfip_pkg::RegSession, {$urandom(), $urandom()});
                write_reg(kfip_pkg::RegFrame, {$urandom(), $urandom()});
            end
            default:
            begin
            end
        endcase
    endtask

    // Sample the result channel at the falling edge, score it at the rising
    // edge where the beat is taken, then draw the next stall.
    always
    begin : result_monitor
        logic                        took;
        logic [kfip_pkg::IndexW-1:0] got;
        logic [kfip_pkg::IndexW-1:0] want;
        @(negedge clk);
        took = rst_n && out_valid && !out_stall;
        got  = mapped_index;
        @(posedge clk);
        if (took)
        begin
            if (pending_maps.size() == 0)
                flag_mismatch("beat with nothing pending", got, '0);
            else
            begin
                want = pending_maps.pop_front();
                if (got !== want)
                    flag_mismatch("mapped_index", got, want);
            end
        end
        out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end

    // Count cycles with no beat and no write; a stuck block ends the run
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= StallLimit)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        kind      <= kfip_pkg::KindForward;
        index     <= '0;
        cfg_write <= 1'b0;
        cfg_index <= kfip_pkg::RegSession;
        cfg_data  <= '0;
        sess_val  = '0;
        frame_val = '0;
        rebuild_round_keys();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats under the reset keys; the block holds in_stall
        // while its key pipeline refills, which the handshake absorbs.
        for (int n = 0; n < NumDirected; n++)
            send_beat(directed_rows[n].dir, directed_rows[n].idx,
                      directed_rows[n].pinned ? directed_rows[n].want :
                      feistel_map(directed_rows[n].dir, directed_rows[n].idx));

        for (int unsigned phase = 0; phase < NumPhases; phase++)
        begin
            // Drop valid and let the block go idle before touching keys
            in_valid <= 1'b0;
            drain_results();
            if (phase < 3)
            begin
                send_idle_pct  = 31;
                recv_stall_pct = 80;
            end
            else if (phase < 6)
            begin
                send_idle_pct  = 80;
                recv_stall_pct = 31;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            apply_setting(phase);
            repeat (BeatsPerPhase) random_beat();
        end

        in_valid <= 1'b0;
        drain_results();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/kfip_pkg.sv
rtl/keyed_feistel_index_permuter.sv
dv/tb_top.sv
